// ===== rtl/rdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdpc_pkg
// Shared types, codes and arithmetic constants of the RGBW dimmer pulse control.
// ----------------------------------------------------------------------------
package rdpc_pkg;

  // PWM period in microseconds; pulse arithmetic widths follow from it
  localparam int PERIOD_US = 10000;

  localparam int PULSE_W   = 14;
  localparam int PULSE_MAX = (1 << PULSE_W) - 1;

  // Microseconds per level step, worked out at elaboration
  localparam int P_STEP = PERIOD_US / 255;

  // Largest value of P_STEP * level * ceiling and its width
  localparam longint unsigned X_MAX = longint'(P_STEP) * 64'd65025;
  localparam int XW = $clog2(X_MAX + 64'd1);

  // x / 255 as (x * DIV_RECIP) >> DIV_SHIFT, exact for every x below 2**XW
  localparam int DIV_SHIFT = XW + 8;
  localparam longint unsigned DIV_RECIP = ((64'd1 << DIV_SHIFT) + 64'd254) / 64'd255;
  localparam int RECIP_W = $clog2(DIV_RECIP + 64'd1);

  // x / 100 as (x * LV_RECIP) >> LV_SHIFT, exact for x below 43690
  localparam int LV_RECIP = 20972;
  localparam int LV_SHIFT = 21;

  localparam int MUL_BW = (RECIP_W > 15) ? RECIP_W : 15;
  localparam int PROD_W = XW + MUL_BW;

  // Largest pulse the arithmetic can reach
  localparam int PULSE_TOP = (P_STEP * 255 > PULSE_MAX) ? PULSE_MAX : P_STEP * 255;

  localparam int DIMMER_MAX   = 100;
  localparam int DIMMER_RESET = 50;

  localparam int QUEUE_DEPTH = 2;

  // Event codes
  localparam logic [1:0] ACT_ONOFF  = 2'd0;
  localparam logic [1:0] ACT_DIMMER = 2'd1;
  localparam logic [1:0] ACT_COLOR  = 2'd2;

  // Channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_WHITE = 2'd3;

  // Register indexes
  localparam logic [2:0] CFG_RED_CEIL   = 3'd0;
  localparam logic [2:0] CFG_GREEN_CEIL = 3'd1;
  localparam logic [2:0] CFG_BLUE_CEIL  = 3'd2;
  localparam logic [2:0] CFG_WHITE_CEIL = 3'd3;
  localparam logic [2:0] CFG_WHITE_EN   = 3'd4;

  // Refresh command: dimmer in force and the color snapshot
  typedef struct packed {
    logic [6:0] dimmer;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rdpc_cmd_t;

  typedef struct packed {
    logic [7:0] red_ceiling;
    logic [7:0] green_ceiling;
    logic [7:0] blue_ceiling;
    logic [7:0] white_ceiling;
    logic       white_enable;
  } rdpc_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LV_MUL,
    ST_LV_DIV,
    ST_PLAN,
    ST_PQ,
    ST_PX,
    ST_PD,
    ST_EMIT
  } rdpc_state_t;

endpackage

// ===== rtl/rdpc_front.sv =====
// ----------------------------------------------------------------------------
// rdpc_front
// Accepts events, keeps color, dimmer and on flag, and queues refresh commands.
// ----------------------------------------------------------------------------
module rdpc_front import rdpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic       light_on,
  input  logic [7:0] dimmer_level,
  input  logic [7:0] red_value,
  input  logic [7:0] green_value,
  input  logic [7:0] blue_value,
  input  logic       q_full,
  output logic       q_push,
  output rdpc_cmd_t  q_cmd
);

  logic [7:0] color [3];
  logic [6:0] dimmer;
  logic       on;
  logic       accept;
  logic [6:0] dim_clamped;

  assign in_stall    = q_full;
  assign accept      = in_valid && !q_full;
  assign dim_clamped = (dimmer_level > 8'(DIMMER_MAX)) ? 7'(DIMMER_MAX) : dimmer_level[6:0];

  always_comb begin
    q_push       = 1'b0;
    q_cmd.dimmer = dimmer;
    q_cmd.red    = color[0];
    q_cmd.green  = color[1];
    q_cmd.blue   = color[2];
    if (accept) begin
      unique case (action)
        ACT_ONOFF: begin
          q_push       = 1'b1;
          q_cmd.dimmer = light_on ? dimmer : '0;
        end
        ACT_DIMMER: begin
          q_push       = on;
          q_cmd.dimmer = dim_clamped;
        end
        ACT_COLOR: begin
          q_push      = on;
          q_cmd.red   = red_value;
          q_cmd.green = green_value;
          q_cmd.blue  = blue_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color[0] <= 8'hFF;
      color[1] <= 8'hFF;
      color[2] <= 8'hFF;
      dimmer   <= 7'(DIMMER_RESET);
      on       <= 1'b1;
    end else if (accept) begin
      unique case (action)
        ACT_ONOFF:  on     <= light_on;
        ACT_DIMMER: dimmer <= dim_clamped;
        ACT_COLOR: begin
          color[0] <= red_value;
          color[1] <= green_value;
          color[2] <= blue_value;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rdpc_queue.sv =====
// ----------------------------------------------------------------------------
// rdpc_queue
// Short first-in first-out queue of refresh commands.
// ----------------------------------------------------------------------------
module rdpc_queue import rdpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rdpc_cmd_t push_cmd,
  input  logic      pop,
  output rdpc_cmd_t head,
  output logic      full,
  output logic      empty
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rdpc_cmd_t        slot [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rdpc_back.sv =====
// ----------------------------------------------------------------------------
// rdpc_back
// Scales the color by the dimmer, routes grey to white and emits channel
// pulses one beat at a time through one shared multiplier.
// ----------------------------------------------------------------------------
module rdpc_back import rdpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  rdpc_cfg_t          cfg,
  input  rdpc_cmd_t          head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         channel,
  output logic [PULSE_W-1:0] pulse_us,
  output logic               last_write
);

  localparam logic [2:0] STEP_WHITE_OFF = 3'd0;
  localparam logic [2:0] STEP_RED       = 3'd1;
  localparam logic [2:0] STEP_GREEN     = 3'd2;
  localparam logic [2:0] STEP_BLUE      = 3'd3;
  localparam logic [2:0] STEP_WHITE     = 3'd4;

  rdpc_state_t state;
  rdpc_state_t state_next;

  logic [1:0]        idx;
  logic [6:0]        dimmer;
  logic [7:0]        col [3];
  logic [7:0]        lv [3];
  logic [7:0]        white_lvl;
  logic [7:0]        wl_now;
  logic              post;
  logic [2:0]        step;
  logic [XW-1:0]     prod;
  logic [PULSE_W-1:0] pulse;

  logic [XW-1:0]     mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] quot;
  logic [PULSE_W-1:0] pulse_sat;
  logic [7:0]        cur_level;
  logic [7:0]        cur_ceil;
  logic [1:0]        cur_chan;
  logic              is_last;
  logic              slot_free;
  logic              grey;
  logic [7:0]        plan_white;
  logic              plan_pre;
  logic              plan_post;

  assign product   = mul_a * mul_b;
  assign quot      = product >> DIV_SHIFT;
  assign pulse_sat = (quot > PROD_W'(PULSE_MAX)) ? PULSE_W'(PULSE_MAX) : quot[PULSE_W-1:0];
  assign slot_free = !out_valid || !out_stall;
  assign is_last   = (step == STEP_WHITE) || (step == STEP_BLUE && !post);

  // Grey test and white plan
  assign grey       = (lv[0] == lv[1]) && (lv[1] == lv[2]);
  assign plan_white = (cfg.white_enable && grey) ? lv[0] : '0;
  assign plan_pre   = cfg.white_enable && (plan_white == '0) && (wl_now != '0);
  assign plan_post  = cfg.white_enable && (plan_white != '0) && (plan_white != wl_now);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (!q_empty) state_next = ST_LV_MUL;
      ST_LV_MUL: state_next = ST_LV_DIV;
      ST_LV_DIV: state_next = (idx == 2'd2) ? ST_PLAN : ST_LV_MUL;
      ST_PLAN:   state_next = ST_PQ;
      ST_PQ:     state_next = ST_PX;
      ST_PX:     state_next = ST_PD;
      ST_PD:     state_next = ST_EMIT;
      ST_EMIT:   if (slot_free) state_next = is_last ? ST_IDLE : ST_PQ;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_level = '0;
    cur_ceil  = cfg.white_ceiling;
    cur_chan  = CH_WHITE;
    case (step)
      STEP_RED: begin
        cur_level = lv[0];
        cur_ceil  = cfg.red_ceiling;
        cur_chan  = CH_RED;
      end
      STEP_GREEN: begin
        cur_level = lv[1];
        cur_ceil  = cfg.green_ceiling;
        cur_chan  = CH_GREEN;
      end
      STEP_BLUE: begin
        cur_level = lv[2];
        cur_ceil  = cfg.blue_ceiling;
        cur_chan  = CH_BLUE;
      end
      STEP_WHITE: begin
        cur_level = white_lvl;
      end
      default: ;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    mul_a = prod;
    mul_b = '0;
    unique case (state)
      ST_IDLE:   q_pop = !q_empty;
      ST_LV_MUL: begin
        mul_a = XW'(col[idx]);
        mul_b = MUL_BW'(dimmer);
      end
      ST_LV_DIV: mul_b = MUL_BW'(LV_RECIP);
      ST_PQ: begin
        mul_a = XW'(cur_level);
        mul_b = MUL_BW'(cur_ceil);
      end
      ST_PX:     mul_b = MUL_BW'(P_STEP);
      ST_PD:     mul_b = MUL_BW'(DIV_RECIP);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wl_now     <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
      step       <= STEP_RED;
      post       <= 1'b0;
    end else begin
      state <= state_next;
      // load a new beat, or drop the one just taken
      if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            dimmer <= head.dimmer;
            col[0] <= head.red;
            col[1] <= head.green;
            col[2] <= head.blue;
            idx    <= '0;
          end
        end
        ST_LV_MUL: prod <= product[XW-1:0];
        ST_LV_DIV: begin
          lv[idx] <= product[LV_SHIFT +: 8];
          idx     <= idx + 1'b1;
        end
        ST_PLAN: begin
          if (cfg.white_enable && grey) begin
            lv[0] <= '0;
            lv[1] <= '0;
            lv[2] <= '0;
          end
          if (cfg.white_enable) begin
            wl_now <= plan_white;
          end
          white_lvl <= plan_white;
          post      <= plan_post;
          step      <= plan_pre ? STEP_WHITE_OFF : STEP_RED;
        end
        ST_PQ: prod <= product[XW-1:0];
        ST_PX: prod <= product[XW-1:0];
        ST_PD: pulse <= pulse_sat;
        ST_EMIT: begin
          if (slot_free) begin
            channel    <= cur_chan;
            pulse_us   <= pulse;
            last_write <= is_last;
            step       <= step + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rgbw_dimmer_pwm_pulse_control.sv =====
// ----------------------------------------------------------------------------
// rgbw_dimmer_pwm_pulse_control
// RGBW dimmer: turns light events into PWM pulse widths per channel.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat is one event: on/off, dimmer
// or color. The front takes a beat, updates the stored color,
// dimmer and on flag, and queues a refresh command when the light must be
// redrawn; events that need no refresh leave no result. in_stall rises only
// while the two-entry command queue is full.
// Output channel (out_valid / out_stall): each beat is one channel write
// (channel, pulse_us); last_write marks the final beat of an event. A refresh
// gives three or four beats: red, green and blue, led by an optional white-off
// or followed by an optional white write, never both.
// The back end pops the queue head and works it through the one shared
// multiplier, a step at a time: scale each color by the dimmer and divide by
// 100, then for each beat level times ceiling, times step, divide by 255. It
// takes the next command only after the last beat of the current one.
// A stalled output beat holds in the output register; the back end waits and
// the front keeps taking events until the queue fills.
// Reset restores color white, dimmer 50, light on, white level 0 and all
// ceilings 255 with the white channel enabled. Config writes are always ready.
// ----------------------------------------------------------------------------
module rgbw_dimmer_pwm_pulse_control import rdpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  // event channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic               light_on,
  input  logic [7:0]         dimmer_level,
  input  logic [7:0]         red_value,
  input  logic [7:0]         green_value,
  input  logic [7:0]         blue_value,
  // channel write channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         channel,
  output logic [PULSE_W-1:0] pulse_us,
  output logic               last_write
);

  rdpc_cfg_t cfg;
  rdpc_cmd_t q_cmd;
  rdpc_cmd_t q_head;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  // Config registers; out-of-range indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_ceiling   <= 8'hFF;
      cfg.green_ceiling <= 8'hFF;
      cfg.blue_ceiling  <= 8'hFF;
      cfg.white_ceiling <= 8'hFF;
      cfg.white_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RED_CEIL:   cfg.red_ceiling   <= cfg_data;
        CFG_GREEN_CEIL: cfg.green_ceiling <= cfg_data;
        CFG_BLUE_CEIL:  cfg.blue_ceiling  <= cfg_data;
        CFG_WHITE_CEIL: cfg.white_ceiling <= cfg_data;
        CFG_WHITE_EN:   cfg.white_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: take events, keep state, classify
  rdpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .light_on     (light_on),
    .dimmer_level (dimmer_level),
    .red_value    (red_value),
    .green_value  (green_value),
    .blue_value   (blue_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Queue: decouple the front from the pulse sequencer
  rdpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: scale, route white, emit pulses
  rdpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel    (channel),
    .pulse_us   (pulse_us),
    .last_write (last_write)
  );

`ifndef SYNTHESIS
  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("refresh command pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("refresh command popped from empty queue");

  // Pulse stays within the reachable range
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_us <= PULSE_W'(PULSE_TOP)))
    else $error("pulse width beyond reachable range");

  // Output register is empty right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present after reset");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGBW dimmer pulse control.
// ----------------------------------------------------------------------------
// Light events go in on the event channel. A model of the lamp inside the
// bench, made of the stored color, dimmer, on flag, white level and the
// register copy, turns every accepted event into the channel writes it must
// cause. A monitor compares each output beat in order against those writes.
// A directed part covers field extremes, every event kind, leaving white,
// zero levels and ceilings, and the white channel being switched off and on.
// Random phases follow, each with its own register setting and idle pattern.
// ----------------------------------------------------------------------------
module tb_top import rdpc_pkg::*; ();

  // Action code that the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One expected channel write
  typedef struct packed {
    logic [1:0]         ch;
    logic [PULSE_W-1:0] pulse;
    logic               last;
  } chan_write_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = CFG_RED_CEIL;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = ACT_ONOFF;
  logic               light_on = 1'b0;
  logic [7:0]         dimmer_level = '0;
  logic [7:0]         red_value = '0;
  logic [7:0]         green_value = '0;
  logic [7:0]         blue_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         channel;
  logic [PULSE_W-1:0] pulse_us;
  logic               last_write;

  // Lamp state as the block should hold it
  logic [7:0]  lamp_rgb [3];
  logic [6:0]  lamp_dimmer;
  logic        lamp_on;
  logic [7:0]  white_now;
  // Register copy, ceilings indexed by channel code
  logic [7:0]  ceil_of [4];
  logic        white_en;

  // Channel writes still owed by the block, oldest first
  chan_write_t owed_writes[$];

  // Idle knobs in percent, changed per phase
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  int unsigned stall_left = 0;

  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned beats_checked;
  int unsigned reg_writes;

  rgbw_dimmer_pwm_pulse_control DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .light_on     (light_on),
    .dimmer_level (dimmer_level),
    .red_value    (red_value),
    .green_value  (green_value),
    .blue_value   (blue_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel      (channel),
    .pulse_us     (pulse_us),
    .last_write   (last_write)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Pulse width in microseconds for one level under one ceiling
  function automatic logic [PULSE_W-1:0] pulse_width(input logic [7:0] level,
                                                      input logic [7:0] ceil_v);
    longint unsigned p;
    if (level == 0 || ceil_v == 0) return '0;
    p = longint'(PERIOD_US / 255);
    p = p * level;
    p = p * ceil_v;
    p = p / 255;
    if (p > PULSE_MAX) p = PULSE_MAX;
    return PULSE_W'(p);
  endfunction

  // Redraw the lamp at the given dimmer: queue every channel write in order
  task automatic plan_refresh(input logic [6:0] dim);
    logic [1:0]  rgb_ch [3] = '{CH_RED, CH_GREEN, CH_BLUE};
    logic [7:0]  lv [3];
    logic [7:0]  white;
    chan_write_t batch[$];
    white = '0;
    for (int i = 0; i < 3; i++) lv[i] = 8'((int'(lamp_rgb[i]) * int'(dim)) / 100);
    if (white_en) begin
      // grey moves to the white channel
      if (lv[0] == lv[1] && lv[1] == lv[2]) begin
        white = lv[0];
        lv    = '{8'd0, 8'd0, 8'd0};
      end
      // leaving white: drop white before touching RGB
      if (white == 0 && white_now != 0) begin
        white_now = '0;
        batch.push_back('{ch: CH_WHITE, pulse: '0, last: 1'b0});
      end
    end
    for (int i = 0; i < 3; i++)
      batch.push_back('{ch: rgb_ch[i], pulse: pulse_width(lv[i], ceil_of[rgb_ch[i]]),
                        last: 1'b0});
    if (white_en && white != white_now) begin
      white_now = white;
      batch.push_back('{ch: CH_WHITE, pulse: pulse_width(white, ceil_of[CH_WHITE]),
                        last: 1'b0});
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) owed_writes.push_back(batch[i]);
  endtask

  // Update the lamp for one accepted event and queue what it must cause
  task automatic predict_event(input logic [1:0] act, input logic turn_on,
                               input logic [7:0] dim, r, g, b);
    case (act)
      ACT_ONOFF: begin
        lamp_on = turn_on;
        plan_refresh(turn_on ? lamp_dimmer : 7'd0);
      end
      ACT_DIMMER: begin
        lamp_dimmer = (dim > DIMMER_MAX) ? 7'(DIMMER_MAX) : dim[6:0];
        if (lamp_on) plan_refresh(lamp_dimmer);
      end
      ACT_COLOR: begin
        lamp_rgb = '{r, g, b};
        if (lamp_on) plan_refresh(lamp_dimmer);
      end
      default: ;
    endcase
  endtask

  // Send one event beat; valid is left high so back-to-back beats never
  // see valid dropped and raised in the same step
  task automatic send_event(input logic [1:0] act, input logic turn_on,
                            input logic [7:0] dim, r, g, b);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    light_on     <= turn_on;
    dimmer_level <= dim;
    red_value    <= r;
    green_value  <= g;
    blue_value   <= b;
    do @(posedge clk); while (in_stall);
    events_sent++;
    predict_event(act, turn_on, dim, r, g, b);
  endtask

  // Wait for every owed write, then let the back end go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_writes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write all five registers; only called while the block is idle
  task automatic program_regs(input logic [7:0] r, g, b, w, input logic en);
    logic [2:0] idx [5] = '{CFG_RED_CEIL, CFG_GREEN_CEIL, CFG_BLUE_CEIL,
                            CFG_WHITE_CEIL, CFG_WHITE_EN};
    logic [7:0] vals [5];
    // upper bits of the enable write are junk the block must ignore
    vals = '{r, g, b, w, {7'($urandom), en}};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      reg_writes++;
      case (idx[i])
        CFG_RED_CEIL:   ceil_of[CH_RED]   = vals[i];
        CFG_GREEN_CEIL: ceil_of[CH_GREEN] = vals[i];
        CFG_BLUE_CEIL:  ceil_of[CH_BLUE]  = vals[i];
        CFG_WHITE_CEIL: ceil_of[CH_WHITE] = vals[i];
        CFG_WHITE_EN:   white_en          = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Ceiling pick that leans on the extremes
  function automatic logic [7:0] pick_ceiling();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random event; returns 0 when it was an ignored action code
  task automatic random_event(output bit counted);
    int unsigned roll;
    logic [1:0]  act;
    logic        turn_on;
    logic [7:0]  dim, r, g, b;
    roll    = $urandom_range(99);
    turn_on = ($urandom_range(4) != 0);
    dim     = ($urandom_range(3) != 0) ? 8'($urandom_range(100)) : 8'($urandom);
    r       = 8'($urandom);
    g       = 8'($urandom);
    b       = 8'($urandom);
    if      (roll < 15) act = ACT_ONOFF;
    else if (roll < 40) act = ACT_DIMMER;
    else if (roll < 95) act = ACT_COLOR;
    else                act = ACT_UNUSED;
    // grey colors keep the white routing busy
    if (act == ACT_COLOR && $urandom_range(9) < 4) begin
      if ($urandom_range(9) == 0) r = '0;
      g = r;
      b = r;
    end
    send_event(act, turn_on, dim, r, g, b);
    counted = (act != ACT_UNUSED);
  endtask

  // Output monitor and stall driver share the edge: sample, then drive
  always @(posedge clk) begin
    chan_write_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (owed_writes.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed: ch %0d pulse %0d last %0b",
                                  channel, pulse_us, last_write));
      end else begin
        want = owed_writes.pop_front();
        if (channel !== want.ch)
          report_mismatch($sformatf("channel %0d, want %0d", channel, want.ch));
        if (pulse_us !== want.pulse)
          report_mismatch($sformatf("pulse_us %0d on ch %0d, want %0d",
                                    pulse_us, want.ch, want.pulse));
        if (last_write !== want.last)
          report_mismatch($sformatf("last_write %0b on ch %0d, want %0b",
                                    last_write, want.ch, want.last));
      end
    end
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < out_stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Reset defaults, field extremes, every action, leaving white, saturation
  task automatic test_directed_events();
    in_gap_pct    = 20;
    out_stall_pct = 20;
    send_event(ACT_COLOR,  1'b0, 8'd0,   8'd255, 8'd255, 8'd255);
    send_event(ACT_DIMMER, 1'b0, 8'd100, 8'd0,   8'd0,   8'd0);
    send_event(ACT_COLOR,  1'b1, 8'd255, 8'd255, 8'd0,   8'd0);
    send_event(ACT_COLOR,  1'b0, 8'd0,   8'd0,   8'd0,   8'd0);
    send_event(ACT_DIMMER, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_event(ACT_COLOR,  1'b0, 8'd0,   8'd200, 8'd200, 8'd200);
    send_event(ACT_DIMMER, 1'b0, 8'd101, 8'd0,   8'd0,   8'd0);
    send_event(ACT_DIMMER, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0);
    send_event(ACT_DIMMER, 1'b0, 8'd1,   8'd0,   8'd0,   8'd0);
    send_event(ACT_COLOR,  1'b0, 8'd0,   8'd99,  8'd99,  8'd99);
    send_event(ACT_DIMMER, 1'b0, 8'd100, 8'd0,   8'd0,   8'd0);
    send_event(ACT_COLOR,  1'b0, 8'd0,   8'd1,   8'd2,   8'd3);
    send_event(ACT_COLOR,  1'b0, 8'd0,   8'd170, 8'd170, 8'd170);
    // off while white is lit, then events that must stay silent
    send_event(ACT_ONOFF,  1'b0, 8'd0,   8'd0,   8'd0,   8'd0);
    send_event(ACT_DIMMER, 1'b1, 8'd77,  8'd255, 8'd255, 8'd255);
    send_event(ACT_COLOR,  1'b1, 8'd255, 8'd10,  8'd20,  8'd30);
    send_event(ACT_UNUSED, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_event(ACT_ONOFF,  1'b1, 8'd0,   8'd0,   8'd0,   8'd0);
    send_event(ACT_ONOFF,  1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
    drain();
  endtask

  // Zero and odd ceilings, white routing switched off and back on
  task automatic test_ceilings_and_white_enable();
    program_regs(8'd0, 8'd255, 8'd1, 8'd128, 1'b1);
    send_event(ACT_COLOR,  1'b0, 8'd0, 8'd255, 8'd0,  8'd128);
    send_event(ACT_COLOR,  1'b0, 8'd0, 8'd90,  8'd90, 8'd90);
    drain();
    // white level stays lit in the block while routing is off
    program_regs(8'd255, 8'd1, 8'd0, 8'd0, 1'b0);
    send_event(ACT_COLOR,  1'b0, 8'd0, 8'd90,  8'd90, 8'd90);
    send_event(ACT_COLOR,  1'b0, 8'd0, 8'd0,   8'd0,  8'd0);
    drain();
    program_regs(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_event(ACT_COLOR,  1'b0, 8'd0, 8'd255, 8'd0,  8'd0);
    send_event(ACT_COLOR,  1'b0, 8'd0, 8'd64,  8'd64, 8'd64);
    drain();
  endtask

  // Random phases, each with its own registers and idle pattern
  task automatic test_random_events();
    int unsigned gap_pct  [5] = '{0, 30, 60, 0, 50};
    int unsigned stl_pct  [5] = '{0, 30, 60, 50, 0};
    int unsigned done;
    bit          counted;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       program_regs(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        2:       program_regs(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        3:       program_regs(pick_ceiling(), pick_ceiling(), pick_ceiling(),
                              pick_ceiling(), 1'b0);
        default: program_regs(pick_ceiling(), pick_ceiling(), pick_ceiling(),
                              pick_ceiling(), 1'($urandom));
      endcase
      in_gap_pct    = gap_pct[ph];
      out_stall_pct = stl_pct[ph];
      done = 0;
      while (done < 60) begin
        random_event(counted);
        if (counted) done++;
      end
      drain();
    end
  endtask

  initial begin
    lamp_rgb      = '{8'hFF, 8'hFF, 8'hFF};
    lamp_dimmer   = 7'(DIMMER_RESET);
    lamp_on       = 1'b1;
    white_now     = '0;
    ceil_of       = '{8'd255, 8'd255, 8'd255, 8'd255};
    white_en      = 1'b1;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    mismatches    = 0;
    events_sent   = 0;
    beats_checked = 0;
    reg_writes    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_ceilings_and_white_enable();
    test_random_events();

    // anything still owed here was never delivered
    if (owed_writes.size() != 0)
      report_mismatch($sformatf("%0d channel writes never arrived", owed_writes.size()));
    $display("Summary: %0d events, %0d channel writes checked, %0d register writes",
             events_sent, beats_checked, reg_writes);
    $display("Summary: %0d mismatches over directed, ceiling and random phases",
             mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #5000000;
    $display("Timeout: %0d channel writes still owed", owed_writes.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rdpc_pkg.sv
rtl/rdpc_front.sv
rtl/rdpc_queue.sv
rtl/rdpc_back.sv
rtl/rgbw_dimmer_pwm_pulse_control.sv
dv/tb_top.sv
